// ----- rtl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; every other file in rtl/ except u8u16_if uses this package.
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CP_W   = 21;   // code point accumulator width
  localparam int UNIT_W = 16;   // UTF-16 code unit width
  localparam int OFF_W  = 20;   // supplementary plane offset width

  localparam logic [OFF_W-1:0]  SUPP_BASE    = 20'h10000;
  localparam logic [UNIT_W-1:0] HI_SURR_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR_BASE = 16'hDC00;

  // One decoded byte's worth of results: a single unit, a surrogate pair or an error.
  typedef struct packed {
    logic              is_error;
    logic              is_pair;
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

// ----- rtl/u8u16_if.sv -----
// Valid/ready channel interfaces: raw UTF-8 bytes in, UTF-16 units out.
// Depends on nothing.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        is_error;
  logic        last_of_run;

  modport source (output valid, output code_unit, output is_error, output last_of_run,
                  input ready);
  modport sink   (input valid, input code_unit, input is_error, input last_of_run,
                  output ready);
endinterface

// ----- rtl/u8u16_front.sv -----
// Front end: accepts UTF-8 bytes, tracks the open sequence and classifies
// each byte into a queue request. Depends on u8u16_pkg and u8u16_if.
module u8u16_front (
  input  logic                clk,
  input  logic                rst_n,
  u8u16_byte_if.sink          in_ch,
  input  logic                full_i,
  output u8u16_pkg::q_push_t  push_o
);

  logic [1:0]                     pend_r, pend_nxt;
  logic [u8u16_pkg::CP_W-1:0]     acc_r, acc_nxt;
  logic [u8u16_pkg::CP_W-1:0]     acc_cont;
  logic [u8u16_pkg::CP_W-1:0]     cp;
  logic [u8u16_pkg::OFF_W-1:0]    off;
  logic [7:0]                     b;
  logic                           emit, err, is_pair, accept;

  assign in_ch.ready = ~full_i;
  assign accept      = in_ch.valid & in_ch.ready;
  assign b           = in_ch.byte_in;
  assign acc_cont    = {acc_r[u8u16_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    err      = 1'b0;
    cp       = '0;
    if (pend_r == 2'd0) begin
      priority if (!b[7]) begin
        emit = 1'b1;
        cp   = {{(u8u16_pkg::CP_W-8){1'b0}}, b};
      end else if (!b[6]) begin
        err = 1'b1;                       // stray continuation byte
      end else if (!b[5]) begin
        acc_nxt  = {{(u8u16_pkg::CP_W-5){1'b0}}, b[4:0]};
        pend_nxt = 2'd1;
      end else if (!b[4]) begin
        acc_nxt  = {{(u8u16_pkg::CP_W-4){1'b0}}, b[3:0]};
        pend_nxt = 2'd2;
      end else if (!b[3]) begin
        acc_nxt  = {{(u8u16_pkg::CP_W-3){1'b0}}, b[2:0]};
        pend_nxt = 2'd3;
      end else begin
        err = 1'b1;                       // 0xF8 and up
      end
    end else begin
      // continuation bytes are taken unchecked
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        emit    = 1'b1;
        cp      = acc_cont;
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_cont;
      end
    end
    // text ends inside a sequence
    if (in_ch.end_of_text && pend_nxt != 2'd0) begin
      err      = 1'b1;
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
  end

  assign is_pair = emit & (cp[u8u16_pkg::CP_W-1:u8u16_pkg::UNIT_W] != '0);
  assign off     = cp[u8u16_pkg::OFF_W-1:0] - u8u16_pkg::SUPP_BASE;

  always_comb begin
    push_o.valid          = accept & (emit | err);
    push_o.entry.is_error = err;
    push_o.entry.is_pair  = is_pair;
    push_o.entry.unit1    = u8u16_pkg::LO_SURR_BASE | {6'b0, off[9:0]};
    if (err) begin
      push_o.entry.unit0 = '0;
    end else if (is_pair) begin
      push_o.entry.unit0 = u8u16_pkg::HI_SURR_BASE | {6'b0, off[19:10]};
    end else begin
      push_o.entry.unit0 = cp[u8u16_pkg::UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ----- rtl/u8u16_queue.sv -----
// Small register FIFO between the front end and the output stage.
// Depends on u8u16_pkg.
module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  u8u16_pkg::q_push_t  push_i,
  output logic                full_o,
  output u8u16_pkg::q_head_t  head_o,
  input  logic                pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full_o       = (count_r == CW'(DEPTH));
  assign do_push      = push_i.valid & ~full_o;
  assign do_pop       = pop_i & (count_r != '0);
  assign head_o.valid = (count_r != '0);
  assign head_o.entry = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign count_nxt  = count_r + CW'(do_push) - CW'(do_pop);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/u8u16_back.sv -----
// Output stage: turns queued requests into one or two UTF-16 results,
// held in an output register. Depends on u8u16_pkg and u8u16_if.
module u8u16_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8u16_pkg::q_head_t  head_i,
  output logic                pop_o,
  u8u16_unit_if.source        out_ch
);

  logic                          valid_r, valid_nxt;
  logic                          half_r, half_nxt;
  logic [u8u16_pkg::UNIT_W-1:0]  unit_r, unit_nxt;
  logic                          err_r, err_nxt;
  logic                          last_r, last_nxt;
  logic                          load;

  assign load = head_i.valid & (~valid_r | out_ch.ready);

  always_comb begin
    valid_nxt = valid_r & ~out_ch.ready;
    half_nxt  = half_r;
    unit_nxt  = unit_r;
    err_nxt   = err_r;
    last_nxt  = last_r;
    pop_o     = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      err_nxt   = head_i.entry.is_error;
      if (head_i.entry.is_pair && !half_r) begin
        // high surrogate first, keep the entry for the low one
        unit_nxt = head_i.entry.unit0;
        last_nxt = 1'b0;
        half_nxt = 1'b1;
      end else begin
        unit_nxt = half_r ? head_i.entry.unit1 : head_i.entry.unit0;
        last_nxt = 1'b1;
        half_nxt = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.code_unit   = unit_r;
  assign out_ch.is_error    = err_r;
  assign out_ch.last_of_run = last_r;

endmodule

// ----- rtl/utf8_to_utf16_decoder_top.sv -----
// UTF-8 to UTF-16 decoder, top level: front end, request queue, output stage.
// Depends on u8u16_pkg, u8u16_if, u8u16_front, u8u16_queue, u8u16_back.
//
// in_ch takes one UTF-8 byte per request, with end_of_text on the final byte of
// a string. out_ch gives UTF-16 code units; last_of_run marks the final result
// caused by a byte, is_error flags a bad lead byte or a truncated sequence
// (code_unit is zero then). Bytes that only extend a sequence give no result.
// An accepted byte's first result goes through the queue, written by the front
// end, and then through the output register, loaded by the output stage.
// Throughput: one byte per cycle while the queue is not full; a surrogate pair
// occupies the output for two results, and the QUEUE_DEPTH-entry queue absorbs
// those bursts. in_ch.ready drops only when the queue is full.
// When out_ch.ready is low the output register holds its result; the front
// end keeps accepting bytes until the queue fills.
// Reset (synchronous, rst_n low) clears the open sequence, the queue and the
// output valid; no results are lost or invented across a stall.
module utf8_to_utf16_decoder_top #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  u8u16_byte_if.sink    in_ch,
  u8u16_unit_if.source  out_ch
);

  u8u16_pkg::q_push_t q_push;
  u8u16_pkg::q_head_t q_head;
  logic               q_full;
  logic               q_pop;

  u8u16_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .full_i (q_full),
    .push_o (q_push)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  u8u16_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_ch (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_full)
    else $error("request pushed into full queue");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_error |-> out_ch.code_unit == 16'h0000 && out_ch.last_of_run)
    else $error("error result with nonzero unit or not last");

  a_pair_high_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_of_run |-> out_ch.code_unit[15:10] == 6'b110110)
    else $error("non-final result is not a high surrogate");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule
